### hw/rtl/bcmp_pkg.sv
// Package with shared types and constants of the binomial coefficient block.
`timescale 1ns / 1ps
`default_nettype none
package bcmp_pkg;
	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int DATA_W = 31;
	localparam int STEP_W = $clog2(DATA_W);
	localparam logic [DATA_W-1:0] MODULUS_RESET = 31'd1000000007;

	typedef struct packed {
		logic start;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
	} mm_req_t;

	typedef struct packed {
		logic done;
		logic [DATA_W-1:0] p;
	} mm_rsp_t;

	typedef enum logic [4:0] {
		ST_FILL_INIT,
		ST_FILL_ZERO,
		ST_FILL_GO,
		ST_FILL_WAIT,
		ST_IDLE,
		ST_RD_N,
		ST_RD_A,
		ST_RD_B,
		ST_RD_LAST,
		ST_POW_GO,
		ST_POW_WAIT,
		ST_SQ_GO,
		ST_SQ_WAIT,
		ST_F1_GO,
		ST_F1_WAIT,
		ST_F2_GO,
		ST_F2_WAIT,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

### hw/rtl/bcmp_modmul.sv
// Bit-serial modular multiplier: one bit of the first operand per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bcmp_modmul (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire bcmp_pkg::mm_req_t          req,
	input  wire logic [bcmp_pkg::DATA_W-1:0] m,
	output bcmp_pkg::mm_rsp_t               rsp
);
	logic [bcmp_pkg::DATA_W-1:0] acc_q;
	logic [bcmp_pkg::DATA_W-1:0] a_q;
	logic [bcmp_pkg::DATA_W-1:0] b_q;
	logic [bcmp_pkg::STEP_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [bcmp_pkg::DATA_W:0]   dbl;
	logic [bcmp_pkg::DATA_W:0]   dbl_red;
	logic [bcmp_pkg::DATA_W:0]   sum;
	logic [bcmp_pkg::DATA_W:0]   sum_red;

	always_comb begin
		dbl = {acc_q, 1'b0};
		dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
		sum = dbl_red + (a_q[bcmp_pkg::DATA_W-1] ? {1'b0, b_q} : '0);
		sum_red = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == bcmp_pkg::STEP_W'(bcmp_pkg::DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q <= req.a;
			b_q <= req.b;
		end else if (busy_q) begin
			acc_q <= sum_red[bcmp_pkg::DATA_W-1:0];
			a_q <= {a_q[bcmp_pkg::DATA_W-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.p = acc_q;
endmodule
`default_nettype wire

### hw/rtl/binomial_coefficient_mod_prime.sv
// Top level of the binomial coefficient modulo a prime block.
`timescale 1ns / 1ps
`default_nettype none
// C(n, r) modulo a prime, from a 4096-entry factorial table and Fermat inversion. All
// arithmetic runs on one bit-serial modular multiplier. After reset and after each
// modulus write the table is rebuilt, one entry per product (all zeros for a modulus
// below two); no query is taken meanwhile. A query then reads the table in the states
// RD_N, RD_A, RD_B and RD_LAST, runs two exponentiations of 31 steps with one or two
// products each, and ends with two final products. Trivial queries (r above n, r equal
// to n, modulus below two) skip the reads and go straight to the output state.
module binomial_coefficient_mod_prime (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [11:0] n_value,
	input  wire logic [11:0] r_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [30:0]      combination_count,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [30:0] modulus
);
	localparam int DW = bcmp_pkg::DATA_W;
	localparam int IW = bcmp_pkg::IDX_W;

	bcmp_pkg::state_t  state_q, state_d;
	bcmp_pkg::mm_req_t mm_req;
	bcmp_pkg::mm_rsp_t mm_rsp;

	logic [DW-1:0] mod_q;
	logic [DW-1:0] expo;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] im_q;
	logic [IW-1:0] im_inc;
	logic [DW-1:0] fval_q;
	logic [IW-1:0] n_q, r_q;
	logic [DW-1:0] fn_q, fb_q, acc_q, base_q, inva_q;
	logic [bcmp_pkg::STEP_W-1:0] bit_q;
	logic          phase_q;
	logic [DW-1:0] res_q;
	logic          out_valid_q;
	logic          mod_small;
	logic          idx_last;
	logic          cfg_fire, in_fire, out_load;

	logic [DW-1:0] fact_mem [bcmp_pkg::TABLE_DEPTH];
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [DW-1:0] wr_data;
	logic [IW-1:0] rd_addr;
	logic [DW-1:0] rd_data_q;

	assign mod_small = (mod_q < DW'(2));
	assign expo = mod_q - DW'(2);
	assign idx_last = (idx_q == IW'(bcmp_pkg::TABLE_DEPTH - 1));
	assign im_inc = im_q + 1'b1;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign in_fire = in_valid && in_ready;

	bcmp_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.m      (mod_q),
		.rsp    (mm_rsp)
	);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fact_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= fact_mem[rd_addr];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bcmp_pkg::ST_FILL_INIT: begin
				state_d = mod_small ? bcmp_pkg::ST_FILL_ZERO : bcmp_pkg::ST_FILL_GO;
			end
			bcmp_pkg::ST_FILL_ZERO: begin
				if (idx_last) state_d = bcmp_pkg::ST_IDLE;
			end
			bcmp_pkg::ST_FILL_GO: state_d = bcmp_pkg::ST_FILL_WAIT;
			bcmp_pkg::ST_FILL_WAIT: begin
				if (mm_rsp.done) begin
					state_d = idx_last ? bcmp_pkg::ST_IDLE : bcmp_pkg::ST_FILL_GO;
				end
			end
			bcmp_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (mod_small || (r_value >= n_value)) state_d = bcmp_pkg::ST_OUT;
					else state_d = bcmp_pkg::ST_RD_N;
				end
			end
			bcmp_pkg::ST_RD_N: state_d = bcmp_pkg::ST_RD_A;
			bcmp_pkg::ST_RD_A: state_d = bcmp_pkg::ST_RD_B;
			bcmp_pkg::ST_RD_B: state_d = bcmp_pkg::ST_RD_LAST;
			bcmp_pkg::ST_RD_LAST: state_d = bcmp_pkg::ST_POW_GO;
			bcmp_pkg::ST_POW_GO: begin
				state_d = expo[bit_q] ? bcmp_pkg::ST_POW_WAIT : bcmp_pkg::ST_SQ_GO;
			end
			bcmp_pkg::ST_POW_WAIT: begin
				if (mm_rsp.done) state_d = bcmp_pkg::ST_SQ_GO;
			end
			bcmp_pkg::ST_SQ_GO: state_d = bcmp_pkg::ST_SQ_WAIT;
			bcmp_pkg::ST_SQ_WAIT: begin
				if (mm_rsp.done) begin
					if (bit_q == bcmp_pkg::STEP_W'(DW - 1)) begin
						state_d = phase_q ? bcmp_pkg::ST_F1_GO : bcmp_pkg::ST_POW_GO;
					end else begin
						state_d = bcmp_pkg::ST_POW_GO;
					end
				end
			end
			bcmp_pkg::ST_F1_GO: state_d = bcmp_pkg::ST_F1_WAIT;
			bcmp_pkg::ST_F1_WAIT: begin
				if (mm_rsp.done) state_d = bcmp_pkg::ST_F2_GO;
			end
			bcmp_pkg::ST_F2_GO: state_d = bcmp_pkg::ST_F2_WAIT;
			bcmp_pkg::ST_F2_WAIT: begin
				if (mm_rsp.done) state_d = bcmp_pkg::ST_OUT;
			end
			bcmp_pkg::ST_OUT: begin
				if (out_load) state_d = bcmp_pkg::ST_IDLE;
			end
			default: state_d = bcmp_pkg::ST_FILL_INIT;
		endcase
		if (cfg_fire) state_d = bcmp_pkg::ST_FILL_INIT;
	end

	always_comb begin
		in_ready = 1'b0;
		cfg_ready = 1'b0;
		out_load = 1'b0;
		wr_en = 1'b0;
		wr_addr = idx_q;
		wr_data = mm_rsp.p;
		rd_addr = n_q;
		mm_req.start = 1'b0;
		mm_req.a = acc_q;
		mm_req.b = base_q;
		case (state_q)
			bcmp_pkg::ST_FILL_INIT: begin
				cfg_ready = 1'b1;
				wr_en = 1'b1;
				wr_addr = '0;
				wr_data = mod_small ? '0 : DW'(1);
			end
			bcmp_pkg::ST_FILL_ZERO: begin
				cfg_ready = 1'b1;
				wr_en = 1'b1;
				wr_data = '0;
			end
			bcmp_pkg::ST_FILL_GO: begin
				cfg_ready = 1'b1;
				mm_req.start = 1'b1;
				mm_req.a = fval_q;
				mm_req.b = DW'(im_q);
			end
			bcmp_pkg::ST_FILL_WAIT: begin
				cfg_ready = 1'b1;
				wr_en = mm_rsp.done;
			end
			bcmp_pkg::ST_IDLE: begin
				cfg_ready = 1'b1;
				in_ready = !cfg_valid;
			end
			bcmp_pkg::ST_RD_N: rd_addr = n_q;
			bcmp_pkg::ST_RD_A: rd_addr = n_q - r_q;
			bcmp_pkg::ST_RD_B: rd_addr = r_q;
			bcmp_pkg::ST_POW_GO: mm_req.start = expo[bit_q];
			bcmp_pkg::ST_SQ_GO: begin
				mm_req.start = 1'b1;
				mm_req.a = base_q;
			end
			bcmp_pkg::ST_F1_GO: begin
				mm_req.start = 1'b1;
				mm_req.a = fn_q;
				mm_req.b = inva_q;
			end
			bcmp_pkg::ST_F2_GO: begin
				mm_req.start = 1'b1;
				mm_req.a = fn_q;
				mm_req.b = acc_q;
			end
			bcmp_pkg::ST_OUT: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcmp_pkg::ST_FILL_INIT;
			mod_q <= bcmp_pkg::MODULUS_RESET;
			out_valid_q <= 1'b0;
			idx_q <= '0;
			im_q <= '0;
			bit_q <= '0;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_fire) mod_q <= modulus;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				bcmp_pkg::ST_FILL_INIT: begin
					idx_q <= IW'(1);
					im_q <= IW'(1);
				end
				bcmp_pkg::ST_FILL_ZERO: idx_q <= idx_q + 1'b1;
				bcmp_pkg::ST_FILL_WAIT: begin
					if (mm_rsp.done) begin
						idx_q <= idx_q + 1'b1;
						im_q <= ({{(DW - IW){1'b0}}, im_inc} == mod_q) ? '0 : im_inc;
					end
				end
				bcmp_pkg::ST_RD_LAST: begin
					bit_q <= '0;
					phase_q <= 1'b0;
				end
				bcmp_pkg::ST_SQ_WAIT: begin
					if (mm_rsp.done) begin
						if (bit_q == bcmp_pkg::STEP_W'(DW - 1)) begin
							bit_q <= '0;
							phase_q <= 1'b1;
						end else begin
							bit_q <= bit_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bcmp_pkg::ST_FILL_INIT: fval_q <= DW'(1);
			bcmp_pkg::ST_FILL_WAIT: begin
				if (mm_rsp.done) fval_q <= mm_rsp.p;
			end
			bcmp_pkg::ST_IDLE: begin
				n_q <= n_value;
				r_q <= r_value;
				fn_q <= (mod_small || (r_value > n_value)) ? '0 : DW'(1);
			end
			bcmp_pkg::ST_RD_A: fn_q <= rd_data_q;
			bcmp_pkg::ST_RD_B: base_q <= rd_data_q;
			bcmp_pkg::ST_RD_LAST: begin
				fb_q <= rd_data_q;
				acc_q <= DW'(1);
			end
			bcmp_pkg::ST_POW_WAIT: begin
				if (mm_rsp.done) acc_q <= mm_rsp.p;
			end
			bcmp_pkg::ST_SQ_WAIT: begin
				if (mm_rsp.done) begin
					if (bit_q == bcmp_pkg::STEP_W'(DW - 1) && !phase_q) begin
						inva_q <= acc_q;
						acc_q <= DW'(1);
						base_q <= fb_q;
					end else begin
						base_q <= mm_rsp.p;
					end
				end
			end
			bcmp_pkg::ST_F1_WAIT: begin
				if (mm_rsp.done) fn_q <= mm_rsp.p;
			end
			bcmp_pkg::ST_F2_WAIT: begin
				if (mm_rsp.done) fn_q <= mm_rsp.p;
			end
			bcmp_pkg::ST_OUT: begin
				if (out_load) res_q <= fn_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign combination_count = res_q;
endmodule
`default_nettype wire
